### hdl/ulrb_pkg.sv
// ----------------------------------------------------------------------------
// ulrb_pkg
// Shared types, codes and helpers for the receive line ring buffer.
// ----------------------------------------------------------------------------
package ulrb_pkg;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [7:0] CMD_MIN_RESET = 8'd14;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic [6:0] max_len;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
      logic [5:0] copied_count;
      logic [7:0] fill_count;
      logic       data_available;
      logic       command_available;
      logic       dropped_oldest;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STATUS,
      ST_SCAN,
      ST_SCAN_CHK,
      ST_PAIR,
      ST_PAIR_CHK,
      ST_DONE,
      ST_EMIT,
      ST_EMIT_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic do_append;
      logic do_clear;
      logic start_read;
      logic rd_emit;
      logic pop;
      logic latch_term;
      logic count_inc;
      logic emit_start;
      logic load_status;
      logic load_byte;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic can_scan;
      logic not_empty;
      logic byte_term;
      logic partner;
      logic count_zero;
      logic emit_last;
      logic slot_free;
   } sts_type;

   function automatic logic is_term(input logic [7:0] c);
      return (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

endpackage

### hdl/ulrb_ctrl.sv
// ----------------------------------------------------------------------------
// ulrb_ctrl
// Sequencer for append, clear and line read operations.
// ----------------------------------------------------------------------------
module ulrb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   output logic              req_stall,
   input  ulrb_pkg::sts_type sts,
   output ulrb_pkg::cmd_type cmd
);

   ulrb_pkg::state_type state_ff;
   ulrb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ulrb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ulrb_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ulrb_pkg::ST_STATUS;
               case (req_op)
                  ulrb_pkg::OP_APPEND: begin
                     cmd.do_append = 1'b1;
                  end
                  ulrb_pkg::OP_READ: begin
                     cmd.start_read = 1'b1;
                     state_in       = ulrb_pkg::ST_SCAN;
                  end
                  ulrb_pkg::OP_CLEAR: begin
                     cmd.do_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ulrb_pkg::ST_STATUS: begin
            if (sts.slot_free) begin
               cmd.load_status = 1'b1;
               state_in        = ulrb_pkg::ST_IDLE;
            end
         end
         ulrb_pkg::ST_SCAN: begin
            state_in = sts.can_scan ? ulrb_pkg::ST_SCAN_CHK : ulrb_pkg::ST_DONE;
         end
         ulrb_pkg::ST_SCAN_CHK: begin
            cmd.pop = 1'b1;
            if (sts.byte_term) begin
               cmd.latch_term = 1'b1;
               state_in       = ulrb_pkg::ST_PAIR;
            end else begin
               cmd.count_inc = 1'b1;
               state_in      = ulrb_pkg::ST_SCAN;
            end
         end
         ulrb_pkg::ST_PAIR: begin
            state_in = sts.not_empty ? ulrb_pkg::ST_PAIR_CHK : ulrb_pkg::ST_DONE;
         end
         ulrb_pkg::ST_PAIR_CHK: begin
            cmd.pop  = sts.partner;
            state_in = ulrb_pkg::ST_DONE;
         end
         ulrb_pkg::ST_DONE: begin
            if (sts.count_zero) begin
               state_in = ulrb_pkg::ST_STATUS;
            end else begin
               cmd.emit_start = 1'b1;
               state_in       = ulrb_pkg::ST_EMIT;
            end
         end
         ulrb_pkg::ST_EMIT: begin
            cmd.rd_emit = 1'b1;
            state_in    = ulrb_pkg::ST_EMIT_OUT;
         end
         ulrb_pkg::ST_EMIT_OUT: begin
            cmd.rd_emit = 1'b1;
            if (sts.slot_free) begin
               cmd.load_byte = 1'b1;
               state_in = sts.emit_last ? ulrb_pkg::ST_IDLE : ulrb_pkg::ST_EMIT;
            end
         end
         default: begin
            state_in = ulrb_pkg::ST_IDLE;
         end
      endcase
   end

   // The partner check is a single decision and always finishes the scan.
   a_pair_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ulrb_pkg::ST_PAIR_CHK |=> state_ff == ulrb_pkg::ST_DONE)
      else $error("partner check did not finish the scan");

endmodule

### hdl/ulrb_dp.sv
// ----------------------------------------------------------------------------
// ulrb_dp
// Byte ring memory, pointers, line counters and the result register.
// ----------------------------------------------------------------------------
module ulrb_dp #(
   parameter int BUF_SIZE = 256,
   parameter int MAX_LINE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ulrb_pkg::req_type req_data,
   input  ulrb_pkg::cmd_type cmd,
   output ulrb_pkg::sts_type sts,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ulrb_pkg::rsp_type rsp_data
);

   localparam int PTR_W  = $clog2(BUF_SIZE);
   localparam int FILL_W = (PTR_W > 8) ? PTR_W : 8;

   logic [7:0]       mem [BUF_SIZE];
   logic [7:0]       mem_q_ff;
   logic [PTR_W-1:0] rd_addr;

   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W-1:0] start_ff;
   logic [PTR_W-1:0] epos_ff;
   logic [5:0]       limit_ff;
   logic [5:0]       count_ff;
   logic [5:0]       ecount_ff;
   logic [7:0]       term_ff;
   logic             dropped_ff;
   logic [7:0]       cmd_min_ff;
   logic             rsp_valid_ff;
   ulrb_pkg::rsp_type rsp_ff;

   logic             full;
   logic [6:0]       len_clip;
   logic [5:0]       limit_in;
   logic [FILL_W-1:0] fill;
   logic [7:0]       fill_sat;

   assign full = (wptr_ff + PTR_W'(1)) == rptr_ff;

   // Lengths above the line limit are clipped; at most len-1 bytes are copied.
   assign len_clip = (req_data.max_len > 7'(MAX_LINE)) ? 7'(MAX_LINE) : req_data.max_len;
   assign limit_in = (len_clip == 7'd0) ? 6'd0 : 6'(len_clip - 7'd1);

   assign fill     = FILL_W'(PTR_W'(wptr_ff - rptr_ff));
   assign fill_sat = (fill > FILL_W'(255)) ? 8'hFF : fill[7:0];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (cmd.do_clear) begin
         wptr_in = '0;
         rptr_in = '0;
      end else if (cmd.do_append) begin
         wptr_in = wptr_ff + PTR_W'(1);
         if (full) begin
            rptr_in = rptr_ff + PTR_W'(1);
         end
      end else if (cmd.pop) begin
         rptr_in = rptr_ff + PTR_W'(1);
      end
   end

   assign rd_addr = cmd.rd_emit ? epos_ff : rptr_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_append) begin
         mem[wptr_ff] <= req_data.data_byte;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         rptr_ff    <= '0;
         cmd_min_ff <= ulrb_pkg::CMD_MIN_RESET;
         count_ff   <= '0;
         limit_ff   <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         if (csr_wr_en) begin
            cmd_min_ff <= csr_wr_data;
         end
         if (cmd.start_read) begin
            limit_ff <= limit_in;
            count_ff <= '0;
         end else if (cmd.count_inc) begin
            count_ff <= count_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dropped_ff <= cmd.do_append && full;
      end
      if (cmd.start_read) begin
         start_ff <= rptr_ff;
      end
      if (cmd.latch_term) begin
         term_ff <= mem_q_ff;
      end
      if (cmd.emit_start) begin
         epos_ff   <= start_ff;
         ecount_ff <= '0;
      end else if (cmd.load_byte) begin
         epos_ff   <= epos_ff + PTR_W'(1);
         ecount_ff <= ecount_ff + 6'd1;
      end
   end

   // Every beat reports the buffer state after the whole operation.
   always_ff @(posedge clock) begin
      if (cmd.load_status || cmd.load_byte) begin
         rsp_ff.fill_count        <= fill_sat;
         rsp_ff.data_available    <= (fill != '0);
         rsp_ff.command_available <= (fill >= FILL_W'(cmd_min_ff));
         rsp_ff.out_byte          <= cmd.load_byte ? mem_q_ff : 8'd0;
         rsp_ff.byte_valid        <= cmd.load_byte;
         rsp_ff.last              <= cmd.load_status || sts.emit_last;
         rsp_ff.copied_count      <= cmd.load_byte ? (ecount_ff + 6'd1) : 6'd0;
         rsp_ff.dropped_oldest    <= cmd.load_status && dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_status || cmd.load_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.not_empty  = (wptr_ff != rptr_ff);
   assign sts.can_scan   = (count_ff < limit_ff) && (wptr_ff != rptr_ff);
   assign sts.byte_term  = ulrb_pkg::is_term(mem_q_ff);
   assign sts.partner    = ulrb_pkg::is_term(mem_q_ff) && (mem_q_ff != term_ff);
   assign sts.count_zero = (count_ff == 6'd0);
   assign sts.emit_last  = ((ecount_ff + 6'd1) == count_ff);
   assign sts.slot_free  = !rsp_valid_ff || !rsp_stall;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= limit_ff)
      else $error("line count passed its limit");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_byte |-> ecount_ff < count_ff)
      else $error("emitted more bytes than were scanned");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_status || cmd.load_byte) |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

### hdl/uart_rx_line_ring_buffer.sv
// ----------------------------------------------------------------------------
// uart_rx_line_ring_buffer
// Receive byte ring buffer with oldest-byte overwrite and a line reader.
// ----------------------------------------------------------------------------
// An append, a clear or an unused op is accepted in the idle state, and the
// single status beat is then loaded into the output register in the status
// state, which waits for a free result slot. A line read first walks the
// ring, with one registered read through the buffer memory's single read port
// and one decision per byte, then checks the partner of a terminator, then
// replays the copied bytes from the same read port, with one registered read
// and one output beat per byte, since every beat must carry the fill level
// after the whole read. A read that copies nothing returns a single status
// beat instead. Result stalls hold up the status and output beats. Reset
// clears the pointers, the line counters and the result valid flag and sets
// the threshold to its default; the buffer memory needs no clearing pass.
// Threshold writes must only come while the block is idle.
module uart_rx_line_ring_buffer #(
   parameter int BUF_SIZE = 256,
   parameter int MAX_LINE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ulrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ulrb_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);

   ulrb_pkg::cmd_type cmd;
   ulrb_pkg::sts_type sts;

   ulrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ulrb_dp #(
      .BUF_SIZE (BUF_SIZE),
      .MAX_LINE (MAX_LINE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
